// File: design/ctd_pkg.sv
`default_nettype none

package ctd_pkg;

  // fixed field widths
  localparam int OUT_W     = 28;
  localparam int CYC_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int ADIV_W    = 3;

  // smallest period register that still holds every reset value
  localparam int PERIOD_RST_W = 15;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MCLK_SOURCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMCLK_SOURCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XT2_OFF        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMCLK_OFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACLK_DIV_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LFXT1_PERIOD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_XT2_PERIOD     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DCO_PERIOD     = 3'd7;

  // master clock source codes
  localparam logic [1:0] MCLK_DCO0  = 2'd0;
  localparam logic [1:0] MCLK_DCO1  = 2'd1;
  localparam logic [1:0] MCLK_XT2   = 2'd2;
  localparam logic [1:0] MCLK_LFXT1 = 2'd3;

  // sub-main clock source codes
  localparam logic SMCLK_DCO = 1'b0;
  localparam logic SMCLK_XT2 = 1'b1;

  // oscillator slots, also the order of the divide sequence
  typedef logic [1:0] osc_t;
  localparam osc_t OSC_LFXT1 = 2'd0;
  localparam osc_t OSC_XT2   = 2'd1;
  localparam osc_t OSC_DCO   = 2'd2;

  localparam logic [15:0] LFXT1_PERIOD_RST = 16'd30517;
  localparam logic [15:0] XT2_PERIOD_RST   = 16'd125;
  localparam logic [15:0] DCO_PERIOD_RST   = 16'd953;

endpackage

`default_nettype wire

// File: design/clock_tree_tick_distributor.sv
// flow: the word is registered, its cycles multiplied into ns, then each running oscillator in turn is
//   divided on the DW = max(PERIOD_WIDTH, 28) + 1 bit divider, a stopped one skipped; the result is registered
// throughput: one word at a time through the shared bit-serial divider, the next accepted only once
//   the result is presented; a held result stalls the input
// reset: synchronous, clears the sequencer, the oscillator remainders and the aclk divider
//   remainder, and loads the default configuration (dco master, periods 30517/125/953 ns)
`default_nettype none

module clock_tree_tick_distributor #(
  parameter int PERIOD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [ctd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [PERIOD_WIDTH-1:0]       cfg_wdata,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctd_pkg::CYC_W-1:0]     cycles,
  input  logic                          cpu_off,
  input  logic                          osc_off,
  input  logic                          scg0,
  input  logic                          scg1,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctd_pkg::OUT_W-1:0]     elapsed_ns,
  output logic [ctd_pkg::OUT_W-1:0]     lfxt1_ticks,
  output logic [ctd_pkg::OUT_W-1:0]     xt2_ticks,
  output logic [ctd_pkg::OUT_W-1:0]     dco_ticks,
  output logic [ctd_pkg::CYC_W-1:0]     mclk_ticks,
  output logic [ctd_pkg::OUT_W-1:0]     aclk_ticks,
  output logic [ctd_pkg::OUT_W-1:0]     aclk_div_ticks,
  output logic [ctd_pkg::OUT_W-1:0]     smclk_ticks
);

  import ctd_pkg::*;

  localparam int PW     = PERIOD_WIDTH;
  // period registers are wide enough for the reset defaults too
  localparam int PRW    = (PW > PERIOD_RST_W) ? PW : PERIOD_RST_W;
  localparam int PROD_W = PRW + CYC_W;
  localparam int MW     = (PROD_W > OUT_W) ? PROD_W : OUT_W + 1;
  localparam int DW     = ((PRW > OUT_W) ? PRW : OUT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_WAIT,
    S_FIN
  } state_t;

  // configuration
  logic [1:0]     mclk_source;
  logic           smclk_source;
  logic           xt2_off;
  logic           smclk_off;
  logic [1:0]     aclk_div_shift;
  logic [PRW-1:0] lfxt1_period;
  logic [PRW-1:0] xt2_period;
  logic [PRW-1:0] dco_period;

  // sequencer and per-word working registers
  state_t           state;
  osc_t             osc;
  logic [CYC_W-1:0] cyc;
  logic             cpu_off_q;
  logic             scg1_q;
  logic [2:0]       run;
  logic [PRW-1:0]   mul_period;
  logic [OUT_W-1:0] ns;
  logic [OUT_W-1:0] ticks [3];

  // state kept across words
  logic [PRW-1:0]    rem_ns [3];
  logic [ADIV_W-1:0] aclk_div_rem;

  // divider interface
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [PRW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quo;
  logic [PRW-1:0] div_rem;

  // combinational helpers
  logic [PRW-1:0]  src_period;
  logic [PRW-1:0]  osc_period;
  logic            lf_run;
  logic            x2_run;
  logic            dc_run;
  logic            mclk_is_dco;
  logic [PROD_W-1:0] prod;
  logic [MW-1:0]   prod_x;
  logic [OUT_W-1:0] ns_sat;
  logic [DW-1:0]   dividend;
  logic [ADIV_W-1:0] div_mask;
  logic [OUT_W:0]  adiv_sum;
  logic            out_free;

  // config writes, low bits kept for the narrow registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mclk_source    <= MCLK_DCO0;
      smclk_source   <= SMCLK_DCO;
      xt2_off        <= 1'b0;
      smclk_off      <= 1'b0;
      aclk_div_shift <= '0;
      lfxt1_period   <= PRW'(LFXT1_PERIOD_RST);
      xt2_period     <= PRW'(XT2_PERIOD_RST);
      dco_period     <= PRW'(DCO_PERIOD_RST);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MCLK_SOURCE:    mclk_source    <= cfg_wdata[1:0];
        REG_SMCLK_SOURCE:   smclk_source   <= cfg_wdata[0];
        REG_XT2_OFF:        xt2_off        <= cfg_wdata[0];
        REG_SMCLK_OFF:      smclk_off      <= cfg_wdata[0];
        REG_ACLK_DIV_SHIFT: aclk_div_shift <= cfg_wdata[1:0];
        REG_LFXT1_PERIOD:   lfxt1_period   <= PRW'(cfg_wdata);
        REG_XT2_PERIOD:     xt2_period     <= PRW'(cfg_wdata);
        REG_DCO_PERIOD:     dco_period     <= PRW'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // master source period, zero period reads as one
  always_comb begin
    case (mclk_source)
      MCLK_LFXT1: src_period = lfxt1_period;
      MCLK_XT2:   src_period = xt2_period;
      default:    src_period = dco_period;
    endcase
    if (src_period == '0) src_period = PRW'(1);
  end

  // period of the oscillator being divided
  always_comb begin
    case (osc)
      OSC_LFXT1: osc_period = lfxt1_period;
      OSC_XT2:   osc_period = xt2_period;
      default:   osc_period = dco_period;
    endcase
    if (osc_period == '0) osc_period = PRW'(1);
  end

  // gating rules, sampled with the word
  assign mclk_is_dco = (mclk_source == MCLK_DCO0) || (mclk_source == MCLK_DCO1);
  assign lf_run = !osc_off || (mclk_source == MCLK_LFXT1 && !cpu_off);
  assign x2_run = !xt2_off || (mclk_source == MCLK_XT2 && !cpu_off) ||
                  (smclk_source == SMCLK_XT2 && !smclk_off);
  assign dc_run = !scg0 || (mclk_is_dco && !cpu_off) ||
                  (smclk_source == SMCLK_DCO && !smclk_off);

  // cycles to ns, saturated at the output range
  assign prod   = PROD_W'(cyc) * PROD_W'(mul_period);
  assign prod_x = MW'(prod);
  assign ns_sat = (prod_x > MW'(OUT_MAX)) ? OUT_MAX : prod_x[OUT_W-1:0];

  // remainder plus elapsed time feeds the divider
  assign dividend = DW'(rem_ns[osc]) + DW'(ns);

  // aclk divider: carry the low shift bits between words
  assign div_mask = ADIV_W'((4'd1 << aclk_div_shift) - 4'd1);
  assign adiv_sum = (OUT_W + 1)'(aclk_div_rem & div_mask) + (OUT_W + 1)'(ticks[OSC_LFXT1]);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      osc          <= OSC_LFXT1;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
      rem_ns[0]    <= '0;
      rem_ns[1]    <= '0;
      rem_ns[2]    <= '0;
      aclk_div_rem <= '0;
    end else begin
      // kick the divider for a running oscillator
      div_start <= (state == S_START) && run[osc];
      // finish reloads the output register itself
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cyc        <= cycles;
            cpu_off_q  <= cpu_off;
            scg1_q     <= scg1;
            run        <= {dc_run, x2_run, lf_run};
            mul_period <= src_period;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          ns    <= ns_sat;
          osc   <= OSC_LFXT1;
          state <= S_START;
        end
        S_START: begin
          if (run[osc]) begin
            div_dividend <= dividend;
            div_divisor  <= osc_period;
            state        <= S_WAIT;
          end else begin
            // stopped oscillator keeps its remainder
            ticks[osc] <= '0;
            if (osc == OSC_DCO) state <= S_FIN;
            else osc <= osc + 1'b1;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            rem_ns[osc] <= div_rem;
            ticks[osc]  <= div_quo[OUT_W-1:0];
            if (osc == OSC_DCO) begin
              state <= S_FIN;
            end else begin
              osc   <= osc + 1'b1;
              state <= S_START;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            elapsed_ns     <= ns;
            lfxt1_ticks    <= ticks[OSC_LFXT1];
            xt2_ticks      <= ticks[OSC_XT2];
            dco_ticks      <= ticks[OSC_DCO];
            aclk_ticks     <= ticks[OSC_LFXT1];
            mclk_ticks     <= cpu_off_q ? '0 : cyc;
            aclk_div_ticks <= OUT_W'(adiv_sum >> aclk_div_shift);
            aclk_div_rem   <= adiv_sum[ADIV_W-1:0] & div_mask;
            if (!scg1_q && !smclk_off) begin
              smclk_ticks <= (smclk_source == SMCLK_XT2) ? ticks[OSC_XT2] : ticks[OSC_DCO];
            end else begin
              smclk_ticks <= '0;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ctd_div #(
    .DW(DW),
    .VW(PRW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  a_accept_mul : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL)
    else $error("accepted word did not start the multiply");

  a_done_wait : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

  a_fin_out : assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_free |=> out_valid && state == S_IDLE)
    else $error("result word not presented after finish");

  a_start_run : assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_WAIT && run[osc])
    else $error("divider started for a stopped oscillator");

endmodule

`default_nettype wire

// File: design/ctd_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module ctd_div #(
  parameter int DW = 29,
  parameter int VW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] q;
  logic [VW-1:0] r;
  logic [VW-1:0] d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted = {r, q[DW-1]};
  assign diff    = shifted - {1'b0, d};
  assign ge      = shifted >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // last quotient bit lands this cycle
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        q   <= {q[DW-2:0], ge};
        r   <= ge ? diff[VW-1:0] : shifted[VW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider not busy after start");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && cnt == '0)
    else $error("divider done while still counting");

  a_rem_below : assert property (@(posedge clk) disable iff (rst)
    done && d != '0 |-> remainder < d)
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: tb/tb_clock_tree_tick_distributor.sv
`default_nettype none

module tb_clock_tree_tick_distributor;
  import ctd_pkg::*;

  localparam int PW          = 20;
  localparam int N_PHASES    = 11;
  localparam int PHASE_WORDS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_NOTES   = 100;

  // one result word, in port order
  typedef struct packed {
    logic [OUT_W-1:0] elapsed;
    logic [OUT_W-1:0] lfxt1;
    logic [OUT_W-1:0] xt2;
    logic [OUT_W-1:0] dco;
    logic [CYC_W-1:0] mclk;
    logic [OUT_W-1:0] aclk;
    logic [OUT_W-1:0] aclk_div;
    logic [OUT_W-1:0] smclk;
  } tick_word_t;

  localparam tick_word_t NO_RES = '0;

  // directed rows: a word to send or a register to write
  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] addr;
    logic [PW-1:0]        data;
    logic [CYC_W-1:0]     cyc;
    logic                 c_off;
    logic                 o_off;
    logic                 s0;
    logic                 s1;
    logic                 typed;
    tick_word_t           want;
  } dir_row_t;

  // typed results only where they are obvious: right after reset with default periods
  localparam dir_row_t DIR_TAB [23] = '{
    // zero cycles from reset: everything zero
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      '{28'd0, 28'd0, 28'd0, 28'd0, 8'd0, 28'd0, 28'd0, 28'd0}},
    // max cycles on the default dco: 255 * 953 ns
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      '{28'd243015, 28'd7, 28'd1944, 28'd255, 8'd255, 28'd7, 28'd7, 28'd255}},
    // all low-power bits set
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
    // widest aclk divider
    '{ROW_CFG, REG_ACLK_DIV_SHIFT, 20'd3, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, NO_RES},
    // divider shrinks with a remainder held: remainder gets masked
    '{ROW_CFG, REG_ACLK_DIV_SHIFT, 20'd1, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    // lfxt1 as master keeps running despite osc_off
    '{ROW_CFG, REG_MCLK_SOURCE, 20'(MCLK_LFXT1), 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, NO_RES},
    // zero period on the master source counts as one
    '{ROW_CFG, REG_LFXT1_PERIOD, 20'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    // xt2 master at the longest period: largest elapsed time
    '{ROW_CFG, REG_MCLK_SOURCE, 20'(MCLK_XT2), 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_XT2_PERIOD, 20'hFFFFF, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    // smclk from xt2, then gated off along with xt2
    '{ROW_CFG, REG_SMCLK_SOURCE, 20'(SMCLK_XT2), 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_XT2_OFF, 20'd1, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_SMCLK_OFF, 20'd1, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, NO_RES},
    // second dco code as master with a zero dco period
    '{ROW_CFG, REG_MCLK_SOURCE, 20'(MCLK_DCO1), 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_CFG, REG_DCO_PERIOD, 20'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, REG_MCLK_SOURCE, 20'd0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES}
  };

  // dut connections, inputs all known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [PW-1:0]        cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [CYC_W-1:0]     cycles    = '0;
  logic                 cpu_off   = 1'b0;
  logic                 osc_off   = 1'b0;
  logic                 scg0      = 1'b0;
  logic                 scg1      = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     elapsed_ns;
  logic [OUT_W-1:0]     lfxt1_ticks;
  logic [OUT_W-1:0]     xt2_ticks;
  logic [OUT_W-1:0]     dco_ticks;
  logic [CYC_W-1:0]     mclk_ticks;
  logic [OUT_W-1:0]     aclk_ticks;
  logic [OUT_W-1:0]     aclk_div_ticks;
  logic [OUT_W-1:0]     smclk_ticks;

  // mirror of the configuration registers
  logic [1:0]    cfg_mclk_src = MCLK_DCO0;
  logic          cfg_sm_src   = SMCLK_DCO;
  logic          cfg_xt2_off  = 1'b0;
  logic          cfg_sm_off   = 1'b0;
  logic [1:0]    cfg_shift    = 2'd0;
  logic [PW-1:0] per_lfxt1    = PW'(LFXT1_PERIOD_RST);
  logic [PW-1:0] per_xt2      = PW'(XT2_PERIOD_RST);
  logic [PW-1:0] per_dco      = PW'(DCO_PERIOD_RST);

  // mirror of the oscillator remainders and the aclk divider remainder
  logic [63:0]       rem_lfxt1 = '0;
  logic [63:0]       rem_xt2   = '0;
  logic [63:0]       rem_dco   = '0;
  logic [ADIV_W-1:0] adiv_rem  = '0;

  tick_word_t pending_ticks[$];
  int         n_mismatch = 0;

  // idling knobs, percent per cycle
  int send_gap_pct = 0;
  int stall_pct    = 0;

  // long receiver hold-off: main bumps the request, the receiver counts it out
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  clock_tree_tick_distributor #(.PERIOD_WIDTH(PW)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cycles         (cycles),
    .cpu_off        (cpu_off),
    .osc_off        (osc_off),
    .scg0           (scg0),
    .scg1           (scg1),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .elapsed_ns     (elapsed_ns),
    .lfxt1_ticks    (lfxt1_ticks),
    .xt2_ticks      (xt2_ticks),
    .dco_ticks      (dco_ticks),
    .mclk_ticks     (mclk_ticks),
    .aclk_ticks     (aclk_ticks),
    .aclk_div_ticks (aclk_div_ticks),
    .smclk_ticks    (smclk_ticks)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // tick predictor
  // ---------------------------------------------------------------------------

  // a zero period register behaves like a one
  function automatic logic [63:0] eff_period(input logic [PW-1:0] p);
    return (p == '0) ? 64'd1 : 64'(p);
  endfunction

  // add elapsed time to one oscillator, keep the remainder, return whole ticks
  function automatic logic [OUT_W-1:0] osc_advance(inout logic [63:0] rem,
                                                   input logic [63:0] ns,
                                                   input logic [PW-1:0] per);
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] q;
    p   = eff_period(per);
    t   = rem + ns;
    rem = t % p;
    q   = t / p;
    return q[OUT_W-1:0];
  endfunction

  function automatic tick_word_t predict_ticks(input logic [CYC_W-1:0] cyc,
                                               input logic c_off, input logic o_off,
                                               input logic s0, input logic s1);
    tick_word_t  r;
    logic [63:0] src_per;
    logic [63:0] ns;
    logic [63:0] msk;
    logic [63:0] sum;
    logic        lf_on;
    logic        x2_on;
    logic        dc_on;
    r = '0;
    case (cfg_mclk_src)
      MCLK_LFXT1: src_per = eff_period(per_lfxt1);
      MCLK_XT2:   src_per = eff_period(per_xt2);
      default:    src_per = eff_period(per_dco);
    endcase
    ns = 64'(cyc) * src_per;
    if (ns > 64'(OUT_MAX)) ns = 64'(OUT_MAX);

    // gating: an oscillator keeps running while something it feeds needs it
    lf_on = !o_off || (cfg_mclk_src == MCLK_LFXT1 && !c_off);
    x2_on = !cfg_xt2_off || (cfg_mclk_src == MCLK_XT2 && !c_off) ||
            (cfg_sm_src == SMCLK_XT2 && !cfg_sm_off);
    dc_on = !s0 || ((cfg_mclk_src == MCLK_DCO0 || cfg_mclk_src == MCLK_DCO1) && !c_off) ||
            (cfg_sm_src == SMCLK_DCO && !cfg_sm_off);

    if (lf_on) r.lfxt1 = osc_advance(rem_lfxt1, ns, per_lfxt1);
    if (x2_on) r.xt2   = osc_advance(rem_xt2, ns, per_xt2);
    if (dc_on) r.dco   = osc_advance(rem_dco, ns, per_dco);

    // aclk divider, leftover masked to the current shift
    msk        = (64'd1 << cfg_shift) - 64'd1;
    sum        = (64'(adiv_rem) & msk) + 64'(r.lfxt1);
    r.aclk_div = OUT_W'(sum >> cfg_shift);
    adiv_rem   = ADIV_W'(sum & msk);

    if (!s1 && !cfg_sm_off) r.smclk = (cfg_sm_src == SMCLK_XT2) ? r.xt2 : r.dco;

    r.elapsed = ns[OUT_W-1:0];
    r.mclk    = c_off ? '0 : cyc;
    r.aclk    = r.lfxt1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one register write, then the enable drops again before return, so enables never toggle within a step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MCLK_SOURCE:    cfg_mclk_src = val[1:0];
      REG_SMCLK_SOURCE:   cfg_sm_src   = val[0];
      REG_XT2_OFF:        cfg_xt2_off  = val[0];
      REG_SMCLK_OFF:      cfg_sm_off   = val[0];
      REG_ACLK_DIV_SHIFT: cfg_shift    = val[1:0];
      REG_LFXT1_PERIOD:   per_lfxt1    = val;
      REG_XT2_PERIOD:     per_xt2      = val;
      REG_DCO_PERIOD:     per_dco      = val;
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // offer one word, predict it on acceptance
  task automatic send_word(input logic [CYC_W-1:0] cyc, input logic c_off,
                           input logic o_off, input logic s0, input logic s1,
                           input logic typed, input tick_word_t want);
    tick_word_t w;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    cycles   <= cyc;
    cpu_off  <= c_off;
    osc_off  <= o_off;
    scg0     <= s0;
    scg1     <= s1;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    w = predict_ticks(cyc, c_off, o_off, s0, s1);
    pending_ticks.push_back(typed ? want : w);
  endtask

  // stop offering and wait for every predicted word to come back
  task automatic wait_results_done();
    if (pending_ticks.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clk);
    end
  endtask

  // periods spread over the edges and the bulk of the range
  function automatic logic [PW-1:0] pick_period();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return PW'($urandom_range(16, 1));
      3:       return PW'($urandom_range(4095, 17));
      default: return PW'($urandom);
    endcase
  endfunction

  // full register set per phase: the first four are fixed, the reset defaults and then three extremes
  task automatic load_phase_config(input int ph);
    logic [1:0]    ms;
    logic          ss;
    logic          xo;
    logic          so;
    logic [1:0]    sh;
    logic [PW-1:0] pl;
    logic [PW-1:0] px;
    logic [PW-1:0] pd;
    case (ph)
      0: begin
        {ms, ss, xo, so, sh} = {MCLK_DCO0, SMCLK_DCO, 1'b0, 1'b0, 2'd0};
        pl = PW'(LFXT1_PERIOD_RST);
        px = PW'(XT2_PERIOD_RST);
        pd = PW'(DCO_PERIOD_RST);
      end
      1: begin
        {ms, ss, xo, so, sh} = {MCLK_LFXT1, SMCLK_XT2, 1'b1, 1'b1, 2'd3};
        {pl, px, pd} = '1;
      end
      2: begin
        {ms, ss, xo, so, sh} = {MCLK_XT2, SMCLK_DCO, 1'b1, 1'b0, 2'd2};
        {pl, px, pd} = {PW'(1), PW'(1), PW'(1)};
      end
      3: begin
        {ms, ss, xo, so, sh} = {MCLK_DCO1, SMCLK_XT2, 1'b0, 1'b1, 2'd1};
        {pl, px, pd} = '0;
      end
      default: begin
        ms = 2'($urandom_range(3));
        ss = 1'($urandom_range(1));
        xo = 1'($urandom_range(1));
        so = 1'($urandom_range(1));
        sh = 2'($urandom_range(3));
        pl = pick_period();
        px = pick_period();
        pd = pick_period();
      end
    endcase
    write_reg(REG_MCLK_SOURCE, PW'(ms));
    write_reg(REG_SMCLK_SOURCE, PW'(ss));
    write_reg(REG_XT2_OFF, PW'(xo));
    write_reg(REG_SMCLK_OFF, PW'(so));
    write_reg(REG_ACLK_DIV_SHIFT, PW'(sh));
    write_reg(REG_LFXT1_PERIOD, pl);
    write_reg(REG_XT2_PERIOD, px);
    write_reg(REG_DCO_PERIOD, pd);
  endtask

  task automatic send_random_word();
    logic [CYC_W-1:0] cyc;
    case ($urandom_range(9))
      0:       cyc = '0;
      1:       cyc = '1;
      default: cyc = CYC_W'($urandom_range(255));
    endcase
    send_word(cyc, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, NO_RES);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------

  // random stalls, plus the long hold-off when main asks for one
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_NOTES) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // compare every accepted result word with the oldest prediction
  always @(posedge clk) begin
    tick_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        note_mismatch("result word with nothing pending");
      end else begin
        want = pending_ticks.pop_front();
        check_field("elapsed_ns", elapsed_ns, want.elapsed);
        check_field("lfxt1_ticks", lfxt1_ticks, want.lfxt1);
        check_field("xt2_ticks", xt2_ticks, want.xt2);
        check_field("dco_ticks", dco_ticks, want.dco);
        check_field("mclk_ticks", OUT_W'(mclk_ticks), OUT_W'(want.mclk));
        check_field("aclk_ticks", aclk_ticks, want.aclk);
        check_field("aclk_div_ticks", aclk_div_ticks, want.aclk_div);
        check_field("smclk_ticks", smclk_ticks, want.smclk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, starting from the reset configuration, no idling
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        wait_results_done();
        write_reg(DIR_TAB[i].addr, DIR_TAB[i].data);
      end else begin
        send_word(DIR_TAB[i].cyc, DIR_TAB[i].c_off, DIR_TAB[i].o_off, DIR_TAB[i].s0,
                  DIR_TAB[i].s1, DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end

    // random phases, each with a fresh register set and its own idling mix
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_results_done();
      load_phase_config(ph);
      case (ph % 4)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 47; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 47; end
        default: begin send_gap_pct = 6;  stall_pct = 6;  end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // receiver backs off while words keep coming: block fills and stalls input
        if (ph == 4 && k == 20) hold_req++;
        // sender goes quiet until the block has drained
        if (ph == 6 && k == PHASE_WORDS / 2) wait_results_done();
        send_random_word();
      end
    end

    wait_results_done();
    repeat (200) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("PASS clock_tree_tick_distributor");
    end else begin
      $display("FAIL clock_tree_tick_distributor");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #8000000;
    $display("FAIL clock_tree_tick_distributor");
    $finish;
  end

endmodule

`default_nettype wire
